// ===== sv/lbcs_pkg.sv =====
`default_nettype none

package lbcs_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned IDX_W   = 3;

	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 8;

	// link modes
	localparam logic [MODE_W-1:0] LINK_TCP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LAST = 3'd5;

	// register indexes
	localparam logic [IDX_W-1:0] REG_MODE_ON    = 3'd0;
	localparam logic [IDX_W-1:0] REG_MODE_OFF   = 3'd1;
	localparam logic [IDX_W-1:0] REG_WEB_PERIOD = 3'd2;
	localparam logic [IDX_W-1:0] REG_WEB_BLINKS = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAP_BASE   = 3'd4;
	localparam logic [IDX_W-1:0] REG_GAP_STEP   = 3'd5;

	localparam logic [MS_W-1:0]    RST_MODE_ON    = 16'd180;
	localparam logic [MS_W-1:0]    RST_MODE_OFF   = 16'd120;
	localparam logic [MS_W-1:0]    RST_WEB_PERIOD = 16'd400;
	localparam logic [COUNT_W-1:0] RST_WEB_BLINKS = 8'd5;
	localparam logic [MS_W-1:0]    RST_GAP_BASE   = 16'd2500;
	localparam logic [MS_W-1:0]    RST_GAP_STEP   = 16'd300;

	typedef struct packed {
		logic [MS_W-1:0]    mode_on_ms;
		logic [MS_W-1:0]    mode_off_ms;
		logic [MS_W-1:0]    web_period_ms;
		logic [COUNT_W-1:0] web_blinks;
		logic [MS_W-1:0]    gap_base_ms;
		logic [MS_W-1:0]    gap_step_ms;
	} cfg_t;

	// one poll, already decoded into what the blink core needs
	typedef struct packed {
		logic [TIME_W-1:0]  now_ms;
		logic               connected;
		logic               run_blink;
		logic [MS_W-1:0]    on_ms;
		logic [MS_W-1:0]    off_ms;
		logic [COUNT_W-1:0] count;
		logic [MS_W-1:0]    gap_ms;
	} poll_t;

endpackage

`default_nettype wire

// ===== sv/lbcs_cfg_regs.sv =====
`default_nettype none

module lbcs_cfg_regs
	import lbcs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [MS_W-1:0]     cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_on_ms    <= RST_MODE_ON;
			cfg_q.mode_off_ms   <= RST_MODE_OFF;
			cfg_q.web_period_ms <= RST_WEB_PERIOD;
			cfg_q.web_blinks    <= RST_WEB_BLINKS;
			cfg_q.gap_base_ms   <= RST_GAP_BASE;
			cfg_q.gap_step_ms   <= RST_GAP_STEP;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE_ON:    cfg_q.mode_on_ms    <= cfg_data;
				REG_MODE_OFF:   cfg_q.mode_off_ms   <= cfg_data;
				REG_WEB_PERIOD: cfg_q.web_period_ms <= cfg_data;
				REG_WEB_BLINKS: cfg_q.web_blinks    <= cfg_data[COUNT_W-1:0];
				REG_GAP_BASE:   cfg_q.gap_base_ms   <= cfg_data;
				REG_GAP_STEP:   cfg_q.gap_step_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/lbcs_blink_core.sv =====
`default_nettype none

module lbcs_blink_core
	import lbcs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire poll_t poll,
	output logic       state_led_next
);

	logic [TIME_W-1:0]  burst_start_q, blink_edge_q;
	logic               burst_active_q, lamp_lit_q, level_q;
	logic [COUNT_W-1:0] blinks_done_q;

	logic [TIME_W-1:0]  since_start, since_edge, interval;
	logic [TIME_W-1:0]  burst_start_d, blink_edge_d;
	logic               burst_active_d, lamp_lit_d, level_d;
	logic [COUNT_W-1:0] blinks_done_d;

	always_comb begin
		since_start = poll.now_ms - burst_start_q;
		since_edge  = poll.now_ms - blink_edge_q;
		interval    = lamp_lit_q ? {{(TIME_W-MS_W){1'b0}}, poll.on_ms}
		                         : {{(TIME_W-MS_W){1'b0}}, poll.off_ms};

		burst_start_d  = burst_start_q;
		blink_edge_d   = blink_edge_q;
		burst_active_d = burst_active_q;
		lamp_lit_d     = lamp_lit_q;
		blinks_done_d  = blinks_done_q;
		level_d        = level_q;

		if (poll.connected) begin
			level_d = 1'b1;
		end else if (poll.run_blink) begin
			if (!burst_active_q) begin
				level_d = 1'b0;
				if (since_start >= {{(TIME_W-MS_W){1'b0}}, poll.gap_ms})
					burst_active_d = 1'b1;
			end
			if (burst_active_d && since_edge >= interval) begin
				blink_edge_d = poll.now_ms;
				lamp_lit_d   = !lamp_lit_q;
				// a turn-off closes one blink
				if (lamp_lit_q)
					blinks_done_d = blinks_done_q + COUNT_W'(1);
				level_d = !lamp_lit_q;
			end
			if (blinks_done_d >= poll.count) begin
				blinks_done_d  = '0;
				lamp_lit_d     = 1'b0;
				burst_active_d = 1'b0;
				blink_edge_d   = '0;
				burst_start_d  = poll.now_ms;
			end
		end
	end

	assign state_led_next = level_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_start_q  <= '0;
			blink_edge_q   <= '0;
			burst_active_q <= 1'b0;
			lamp_lit_q     <= 1'b0;
			blinks_done_q  <= '0;
			level_q        <= 1'b0;
		end else if (step) begin
			burst_start_q  <= burst_start_d;
			blink_edge_q   <= blink_edge_d;
			burst_active_q <= burst_active_d;
			lamp_lit_q     <= lamp_lit_d;
			blinks_done_q  <= blinks_done_d;
			level_q        <= level_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/led_blink_code_sequencer_top.sv =====
`default_nettype none

// Drives a state LED and an air-ready level from a stream of polls, one
// result beat per input beat. Each poll's mode timing (on, off, blink count
// and burst gap) is looked up as the poll enters the input register; when
// the output register is free or drained, a single pass of compare-and-update
// logic steps the blink state and loads the output register. A poll can be
// accepted every cycle while m_axis_tready does not hold the output, and the
// output register lets a new poll in while a result still waits. Configuration
// writes are always accepted and must only be made while no poll is in flight.
module led_blink_code_sequencer_top
	import lbcs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// now_ms[31:0], connected[32], tcp_client_up[33], web_setup[34], mode[37:35]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// state_led[0], air_ready_led[1]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,

	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [IDX_W-1:0]       cfg_index,
	input  wire logic [MS_W-1:0]        cfg_data
);

	cfg_t cfg;

	lbcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input field decode
	logic [TIME_W-1:0] in_now;
	logic              in_conn, in_tcp, in_web;
	logic [MODE_W-1:0] in_mode;
	logic              mode_blinks;
	logic [MS_W+MODE_W-1:0] gap_dec;
	logic [MS_W-1:0]   mode_gap;
	poll_t             poll_d;
	logic              air_d;

	assign in_now  = s_axis_tdata[TIME_W-1:0];
	assign in_conn = s_axis_tdata[TIME_W];
	assign in_tcp  = s_axis_tdata[TIME_W+1];
	assign in_web  = s_axis_tdata[TIME_W+2];
	assign in_mode = s_axis_tdata[TIME_W+3 +: MODE_W];

	always_comb begin
		mode_blinks = (in_mode >= LINK_TCP) && (in_mode <= MODE_LAST);
		gap_dec     = {{MODE_W{1'b0}}, cfg.gap_step_ms} * {{MS_W{1'b0}}, in_mode};
		mode_gap    = (gap_dec >= {{MODE_W{1'b0}}, cfg.gap_base_ms}) ? '0
		              : cfg.gap_base_ms - gap_dec[MS_W-1:0];

		poll_d.now_ms    = in_now;
		poll_d.connected = in_conn;
		poll_d.run_blink = !in_conn && (in_web || mode_blinks);
		if (in_web) begin
			poll_d.on_ms  = cfg.web_period_ms;
			poll_d.off_ms = cfg.web_period_ms;
			poll_d.count  = cfg.web_blinks;
			poll_d.gap_ms = cfg.web_period_ms;
		end else begin
			poll_d.on_ms  = cfg.mode_on_ms;
			poll_d.off_ms = cfg.mode_off_ms;
			poll_d.count  = {{(COUNT_W-MODE_W){1'b0}}, in_mode};
			poll_d.gap_ms = mode_gap;
		end
		air_d = in_conn && ((in_mode != LINK_TCP) || in_tcp);
	end

	// input register and output register handshakes
	logic  valid_s1;
	poll_t poll_s1;
	logic  air_s1;
	logic  out_valid_q;
	logic  state_led_q, air_q;
	logic  advance, in_beat, state_led_next;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_beat)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			poll_s1 <= poll_d;
			air_s1  <= air_d;
		end
		if (advance && valid_s1) begin
			state_led_q <= state_led_next;
			air_q       <= air_s1;
		end
	end

	lbcs_blink_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (valid_s1 && advance),
		.poll           (poll_s1),
		.state_led_next (state_led_next)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, air_q, state_led_q};

endmodule

`default_nettype wire
